// File: sv/aetg_pkg.sv
// shared types, character codes and helpers for the ansi escape text grid
package aetg_pkg;

   localparam int ROWS_DEF      = 32;
   localparam int COLS_DEF      = 128;
   localparam int PARAM_MAX_DEF = 63;

   localparam logic [15:0] NUM_MAX = 16'hFFFF;

   // stream characters
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   // csi final bytes
   localparam logic [7:0] CMD_UP    = 8'h41;  // A
   localparam logic [7:0] CMD_DOWN  = 8'h42;  // B
   localparam logic [7:0] CMD_RIGHT = 8'h43;  // C
   localparam logic [7:0] CMD_LEFT  = 8'h44;  // D
   localparam logic [7:0] CMD_POS   = 8'h48;  // H
   localparam logic [7:0] CMD_CLEAR = 8'h4A;  // J
   localparam logic [7:0] CMD_ERASE = 8'h4B;  // K
   localparam logic [7:0] CMD_POS_F = 8'h66;  // f

   // number phase codes
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_SWEEP = 3'b100
   } ctl_state_type;

   typedef enum logic [4:0] {
      PM_GROUND  = 5'b00001,
      PM_ESC     = 5'b00010,
      PM_CSI     = 5'b00100,
      PM_OSC     = 5'b01000,
      PM_OSC_ESC = 5'b10000
   } parse_mode_type;

   // n * 10 + d, saturating at 16 bits
   function automatic logic [15:0] add_digit(input logic [15:0] n, input logic [3:0] d);
      logic [19:0] v;
      v = {1'b0, n, 3'b000} + {3'b000, n, 1'b0} + {16'd0, d};
      return (v > {4'd0, NUM_MAX}) ? NUM_MAX : v[15:0];
   endfunction

endpackage

// File: sv/ansi_escape_text_grid_core.sv
// ansi escape text grid: stream parser, cursor and character grid memory
//
// Input channel req_*: req_kind 0 feeds req_data_byte to the escape parser,
// req_kind 1 reads the cell at req_read_row / req_read_col. Each item gives
// exactly one rsp_* item: rsp_cell_char (0 for byte items, 0 for reads
// outside the grid) and the cursor position after the item.
// A byte item's rsp item is registered and ready the next cycle, so bytes
// stream at one per cycle while rsp_ready is high and no walk runs. A read
// item passes the registered memory read port, then ST_READ, before its rsp
// item is registered. Clear screen (CSI J) writes one cell a cycle through
// the single memory write port and holds req_ready low until the whole grid
// is written; erase line (CSI K) does the same from the cursor column to the
// end of the row. The rsp item of those bytes is out before the walk ends.
// Reset clears the cursor and parser and starts a clearing pass that fills
// the grid with spaces, with req_ready low.
// A stalled rsp item holds its payload; while it waits no new item is taken
// unless rsp_ready is high in the same cycle.
module ansi_escape_text_grid_core
   import aetg_pkg::*;
#(
   parameter int ROWS      = ROWS_DEF,
   parameter int COLS      = COLS_DEF,
   parameter int PARAM_MAX = PARAM_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_data_byte,
   input  logic [4:0] req_read_row,
   input  logic [6:0] req_read_col,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_cell_char,
   output logic [4:0] rsp_cursor_row,
   output logic [7:0] rsp_cursor_col
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW    = $clog2(COLS + 1);
   localparam int PLW   = $clog2(PARAM_MAX + 1);

   localparam logic [16:0]    ROW_LAST  = 17'(ROWS - 1);
   localparam logic [16:0]    COL_LAST  = 17'(COLS - 1);
   localparam logic [AW-1:0]  ADDR_LAST = AW'(DEPTH - 1);

   ctl_state_type  state_ff, state_in;
   parse_mode_type mode_ff, mode_in;
   logic [RW-1:0]  row_pos_ff, row_pos_in;
   logic [CW-1:0]  col_pos_ff, col_pos_in;
   logic [15:0]    first_num_ff, first_num_in;
   logic [15:0]    second_num_ff, second_num_in;
   logic [PLW-1:0] plen_ff, plen_in;
   logic [1:0]     phase_ff, phase_in;
   logic [AW-1:0]  sweep_addr_ff, sweep_addr_in;
   logic [AW-1:0]  sweep_end_ff, sweep_end_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     cell_char_ff, cell_char_in;
   logic [7:0]     rd_data_ff;
   logic           read_hit_ff;

   logic [7:0]     char_grid_mem [DEPTH];

   logic           req_accept;
   logic [7:0]     b;
   logic           is_digit, is_param;
   logic [15:0]    num_d, num_c, d_m1, c_m1;
   logic [16:0]    row_sum, col_sum;
   logic [RW-1:0]  h_row, a_row, b_row, lf_row;
   logic [CW-1:0]  h_col, c_col, d_col;
   logic [AW-1:0]  row_base, cur_addr, line_end;
   logic           col_in_line;
   logic           rd_en, rd_hit;
   logic [15:0]    rd_addr_wide;
   logic [AW-1:0]  rd_addr;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [7:0]     mem_wdata;
   logic [7:0]     row_wide;
   logic [15:0]    col_wide;

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign b          = req_data_byte;

   assign is_digit = (b inside {[CH_ZERO:CH_NINE]});
   assign is_param = is_digit || (b == CH_SEMI) || (b == CH_QUEST);

   // missing or zero counts act as one
   assign num_d = (first_num_ff == 16'd0) ? 16'd1 : first_num_ff;
   assign num_c = (second_num_ff == 16'd0) ? 16'd1 : second_num_ff;
   assign d_m1  = num_d - 16'd1;
   assign c_m1  = num_c - 16'd1;

   assign h_row = ({1'b0, d_m1} > ROW_LAST) ? RW'(ROW_LAST) : RW'(d_m1);
   assign h_col = ({1'b0, c_m1} > COL_LAST) ? CW'(COL_LAST) : CW'(c_m1);
   assign a_row = (num_d >= 16'(row_pos_ff)) ? '0 : RW'(16'(row_pos_ff) - num_d);
   assign row_sum = 17'(row_pos_ff) + 17'(num_d);
   assign b_row = (row_sum > ROW_LAST) ? RW'(ROW_LAST) : RW'(row_sum);
   assign col_sum = 17'(col_pos_ff) + 17'(num_d);
   assign c_col = (col_sum > COL_LAST) ? CW'(COL_LAST) : CW'(col_sum);
   assign d_col = (num_d >= 16'(col_pos_ff)) ? '0 : CW'(16'(col_pos_ff) - num_d);
   assign lf_row = (17'(row_pos_ff) + 17'd1 < 17'(ROWS)) ? RW'(17'(row_pos_ff) + 17'd1)
                                                      : RW'(ROW_LAST);

   assign col_in_line = (col_pos_ff < CW'(COLS));
   assign row_base    = AW'(AW'(row_pos_ff) * AW'(COLS));
   assign cur_addr    = row_base + AW'(col_pos_ff);
   assign line_end    = row_base + AW'(COLS - 1);

   assign rd_en        = req_accept && req_kind;
   assign rd_hit       = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLS);
   assign rd_addr_wide = 16'(req_read_row) * 16'(COLS) + 16'(req_read_col);
   assign rd_addr      = rd_addr_wide[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      row_pos_in    = row_pos_ff;
      col_pos_in    = col_pos_ff;
      first_num_in  = first_num_ff;
      second_num_in = second_num_ff;
      plen_in       = plen_ff;
      phase_in      = phase_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_end_in  = sweep_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cell_char_in  = cell_char_ff;
      mem_we        = 1'b0;
      mem_waddr     = sweep_addr_ff;
      mem_wdata     = CH_SPACE;

      case (state_ff)
         ST_SWEEP: begin
            mem_we = 1'b1;
            if (sweep_addr_ff == sweep_end_ff) begin
               state_in = ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + AW'(1);
            end
         end
         ST_READ: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               cell_char_in = read_hit_ff ? rd_data_ff : 8'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            if (req_accept && req_kind) begin
               state_in = ST_READ;
            end else if (req_accept) begin
               rsp_valid_in = 1'b1;
               cell_char_in = 8'd0;
               case (mode_ff)
                  PM_ESC: begin
                     if (b == CH_LBRACK) begin
                        mode_in       = PM_CSI;
                        first_num_in  = '0;
                        second_num_in = '0;
                        plen_in       = '0;
                        phase_in      = PH_FIRST;
                     end else if (b == CH_RBRACK) begin
                        mode_in = PM_OSC;
                     end else begin
                        mode_in = PM_GROUND;
                     end
                  end
                  PM_CSI: begin
                     if (plen_ff < PLW'(PARAM_MAX) && is_param) begin
                        plen_in = plen_ff + PLW'(1);
                        if (b == CH_SEMI) begin
                           if (phase_ff != PH_DONE) begin
                              phase_in = phase_ff + 2'd1;
                           end
                        end else if (b == CH_QUEST) begin
                           phase_in = PH_DONE;
                        end else if (phase_ff == PH_FIRST) begin
                           first_num_in = add_digit(first_num_ff, b[3:0]);
                        end else if (phase_ff == PH_SECOND) begin
                           second_num_in = add_digit(second_num_ff, b[3:0]);
                        end
                     end else begin
                        // anything else, or any byte once plen reaches PARAM_MAX, is the final byte
                        mode_in = PM_GROUND;
                        case (b)
                           CMD_POS, CMD_POS_F: begin
                              row_pos_in = h_row;
                              col_pos_in = h_col;
                           end
                           CMD_CLEAR: begin
                              state_in      = ST_SWEEP;
                              sweep_addr_in = '0;
                              sweep_end_in  = ADDR_LAST;
                           end
                           CMD_ERASE: begin
                              if (col_in_line) begin
                                 state_in      = ST_SWEEP;
                                 sweep_addr_in = cur_addr;
                                 sweep_end_in  = line_end;
                              end
                           end
                           CMD_UP:    row_pos_in = a_row;
                           CMD_DOWN:  row_pos_in = b_row;
                           CMD_RIGHT: col_pos_in = c_col;
                           CMD_LEFT:  col_pos_in = d_col;
                           default: ;
                        endcase
                     end
                  end
                  PM_OSC_ESC: begin
                     if (b == CH_BSLASH || b == CH_BEL) begin
                        mode_in = PM_GROUND;
                     end else if (b == CH_ESC) begin
                        mode_in = PM_OSC_ESC;
                     end else begin
                        mode_in = PM_OSC;
                     end
                  end
                  PM_OSC: begin
                     if (b == CH_BEL) begin
                        mode_in = PM_GROUND;
                     end else if (b == CH_ESC) begin
                        mode_in = PM_OSC_ESC;
                     end
                  end
                  default: begin
                     if (b == CH_ESC) begin
                        mode_in = PM_ESC;
                     end else if (b == CH_CR) begin
                        col_pos_in = '0;
                     end else if (b == CH_LF) begin
                        col_pos_in = '0;
                        row_pos_in = lf_row;
                     end else if (b == CH_BS) begin
                        if (col_pos_ff != '0) begin
                           col_pos_in = col_pos_ff - CW'(1);
                        end
                     end else if (col_in_line) begin
                        // printable and other control bytes land at the cursor
                        mem_we     = 1'b1;
                        mem_waddr  = cur_addr;
                        mem_wdata  = b;
                        col_pos_in = col_pos_ff + CW'(1);
                     end
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         mode_ff       <= PM_GROUND;
         row_pos_ff    <= '0;
         col_pos_ff    <= '0;
         first_num_ff  <= '0;
         second_num_ff <= '0;
         plen_ff       <= '0;
         phase_ff      <= PH_FIRST;
         sweep_addr_ff <= '0;
         sweep_end_ff  <= ADDR_LAST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         row_pos_ff    <= row_pos_in;
         col_pos_ff    <= col_pos_in;
         first_num_ff  <= first_num_in;
         second_num_ff <= second_num_in;
         plen_ff       <= plen_in;
         phase_ff      <= phase_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_end_ff  <= sweep_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_char_ff <= cell_char_in;
      if (rd_en) begin
         read_hit_ff <= rd_hit;
      end
   end

   // grid memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         char_grid_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= char_grid_mem[rd_addr];
      end
   end

   assign row_wide = 8'(row_pos_ff);
   assign col_wide = 16'(col_pos_ff);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = cell_char_ff;
   assign rsp_cursor_row = row_wide[4:0];
   assign rsp_cursor_col = col_wide[7:0];

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("item taken while reading or walking the grid");

   a_read_goes_wait: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind) |=> (state_ff == ST_READ) && !rsp_valid_ff)
      else $error("read item did not wait for memory data");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (sweep_addr_ff <= sweep_end_ff))
      else $error("grid walk ran past its end");

   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      (32'(row_pos_ff) < ROWS) && (32'(col_pos_ff) <= COLS))
      else $error("cursor outside grid");

   a_byte_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_kind) |=> rsp_valid_ff && (cell_char_ff == 8'd0))
      else $error("byte item gave no result");

endmodule
